// ===== sv/slbm_pkg.sv =====
`timescale 1ns / 1ps

package slbm_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CFG_PRG_BANK_COUNT    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_VERT_MIRROR = 1'd1;

  localparam logic [4:0] CTRL_RESET_VAL     = 5'h0C;
  localparam logic [4:0] PRG_COUNT_RESET    = 5'd2;
  localparam logic       MIRROR_RESET       = 1'b0;

  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  localparam logic [1:0] MIRROR_CODE_VERT  = 2'd2;
  localparam logic [1:0] MIRROR_CODE_HORIZ = 2'd3;

  localparam logic [1:0] REG_SEL_CONTROL = 2'd0;
  localparam logic [1:0] REG_SEL_CHR_LOW = 2'd1;
  localparam logic [1:0] REG_SEL_CHR_HI  = 2'd2;
  localparam logic [1:0] REG_SEL_PRG     = 2'd3;

  localparam logic [2:0] SERIAL_LAST = 3'd5;

  typedef enum logic [2:0] {
    TGT_CHR      = 3'd0,
    TGT_PRG_RAM  = 3'd1,
    TGT_PRG_ROM  = 3'd2,
    TGT_UNMAPPED = 3'd3,
    TGT_REG_WR   = 3'd4
  } target_t;

  typedef struct packed {
    logic [4:0] serial_value;
    logic [2:0] serial_count;
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [3:0] prg_sel;
    logic [4:0] prg_bank_count;
    logic       mirror;
  } map_state_t;

  typedef struct packed {
    target_t     target;
    logic [17:0] offset;
    logic        store_enable;
    logic [7:0]  store_data;
    logic        mirror_vertical;
  } map_result_t;

endpackage

// ===== sv/slbm_regs.sv =====
`timescale 1ns / 1ps

module slbm_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [slbm_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [slbm_pkg::CfgDataW-1:0]    cfg_wdata,
  input  logic                             step,
  input  logic                             opcode,
  input  logic [15:0]                      address,
  input  logic [7:0]                       data_in,
  output slbm_pkg::map_state_t             state,
  output logic                             mirror_after
);

  slbm_pkg::map_state_t st_r;
  slbm_pkg::map_state_t st_nxt;
  logic                 reg_wr;
  logic [2:0]           cnt_inc;
  logic [4:0]           shift_val;
  logic                 refresh;

  always_comb begin
    st_nxt    = st_r;
    reg_wr    = step && (opcode == slbm_pkg::OP_WRITE) && address[15];
    cnt_inc   = st_r.serial_count + 3'd1;
    shift_val = {data_in[0], st_r.serial_value[4:1]};
    refresh   = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        slbm_pkg::CFG_PRG_BANK_COUNT:    st_nxt.prg_bank_count = cfg_wdata;
        slbm_pkg::CFG_START_VERT_MIRROR: st_nxt.mirror = cfg_wdata[0];
        default: ;
      endcase
    end

    if (reg_wr) begin
      if (data_in[7]) begin
        st_nxt.serial_value = '0;
        st_nxt.serial_count = '0;
        st_nxt.control      = st_r.control | slbm_pkg::CTRL_RESET_VAL;
        refresh             = 1'b1;
      end else if (cnt_inc >= slbm_pkg::SERIAL_LAST) begin
        st_nxt.serial_value = '0;
        st_nxt.serial_count = '0;
        refresh             = 1'b1;
        unique case (address[14:13])
          slbm_pkg::REG_SEL_CONTROL: st_nxt.control  = shift_val;
          slbm_pkg::REG_SEL_CHR_LOW: st_nxt.chr_low  = shift_val;
          slbm_pkg::REG_SEL_CHR_HI:  st_nxt.chr_high = shift_val;
          slbm_pkg::REG_SEL_PRG:     st_nxt.prg_sel  = shift_val[3:0];
          default: ;
        endcase
      end else begin
        st_nxt.serial_value = shift_val;
        st_nxt.serial_count = cnt_inc;
      end
    end

    if (refresh) begin
      if (st_nxt.control[1:0] == slbm_pkg::MIRROR_CODE_VERT) begin
        st_nxt.mirror = 1'b1;
      end else if (st_nxt.control[1:0] == slbm_pkg::MIRROR_CODE_HORIZ) begin
        st_nxt.mirror = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.serial_value   <= '0;
      st_r.serial_count   <= '0;
      st_r.control        <= slbm_pkg::CTRL_RESET_VAL;
      st_r.chr_low        <= '0;
      st_r.chr_high       <= '0;
      st_r.prg_sel        <= '0;
      st_r.prg_bank_count <= slbm_pkg::PRG_COUNT_RESET;
      st_r.mirror         <= slbm_pkg::MIRROR_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign state        = st_r;
  assign mirror_after = st_nxt.mirror;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.serial_count < slbm_pkg::SERIAL_LAST)
    else $error("serial count out of range");

  a_reset_write_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (reg_wr && data_in[7]) |=> (st_r.control[3:2] == 2'b11 && st_r.serial_count == 3'd0))
    else $error("reset write did not force control bits");

  a_no_reg_change: assert property (@(posedge clk) disable iff (!rst_n)
    (!reg_wr && !cfg_we) |=> ($stable(st_r.control) && $stable(st_r.serial_count)
                              && $stable(st_r.mirror)))
    else $error("mapper state changed without a register write");

endmodule

// ===== sv/slbm_map.sv =====
`timescale 1ns / 1ps

module slbm_map (
  input  slbm_pkg::map_state_t  state,
  input  logic                  mirror_after,
  input  logic                  opcode,
  input  logic [15:0]           address,
  input  logic [7:0]            data_in,
  output slbm_pkg::map_result_t result
);

  logic [4:0] chr_bank;
  logic [3:0] prg_bank;
  logic       chr_upper;
  logic       prg_upper;
  logic [4:0] last_bank;

  always_comb begin
    chr_upper = address[12];
    prg_upper = address[14];
    last_bank = state.prg_bank_count - 5'd1;

    if (state.control[4]) begin
      chr_bank = chr_upper ? state.chr_high : state.chr_low;
    end else begin
      chr_bank = {state.chr_low[4:1], chr_upper};
    end

    if (state.control[3]) begin
      if (state.control[2]) begin
        prg_bank = prg_upper ? last_bank[3:0] : state.prg_sel;
      end else begin
        prg_bank = prg_upper ? state.prg_sel : 4'd0;
      end
    end else begin
      prg_bank = {state.prg_sel[3:1], prg_upper};
    end

    result.target          = slbm_pkg::TGT_UNMAPPED;
    result.offset          = '0;
    result.store_enable    = 1'b0;
    result.store_data      = '0;
    result.mirror_vertical = mirror_after;

    priority if (address[15:13] == 3'b000) begin
      result.target       = slbm_pkg::TGT_CHR;
      result.offset       = {1'b0, chr_bank, address[11:0]};
      result.store_enable = opcode;
    end else if (address[15:13] == 3'b011) begin
      result.target       = slbm_pkg::TGT_PRG_RAM;
      result.offset       = {5'd0, address[12:0]};
      result.store_enable = opcode;
    end else if (!address[15]) begin
      result.target = slbm_pkg::TGT_UNMAPPED;
    end else if (opcode == slbm_pkg::OP_READ) begin
      result.target = slbm_pkg::TGT_PRG_ROM;
      result.offset = {prg_bank, address[13:0]};
    end else begin
      result.target = slbm_pkg::TGT_REG_WR;
    end

    if (result.store_enable) begin
      result.store_data = data_in;
    end
  end

endmodule

// ===== sv/serial_loaded_bank_mapper_top.sv =====
`timescale 1ns / 1ps
// channel | ports    | tuser         | tdata
// --------+----------+---------------+-------------------------------------------
// in      | in_*     | [0] opcode    | [15:0] address, [23:16] data_in
// out     | out_*    | [2:0] target  | [17:0] offset, [18] store_enable,
//         |          |               | [26:19] store_data, [27] mirror_vertical
// cfg     | cfg_*    | index 0 prg_bank_count, index 1 start_vertical_mirror
//
// One request per cycle while results are accepted; stages: input register,
// decode and serial load, result register.
// Reset (rst_n, synchronous) empties both registers and restores the mapper state.
// A stalled result holds the input register; a new request is still taken in
// the cycle the result leaves.

module serial_loaded_bank_mapper_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [slbm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slbm_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // address, data_in
  input  logic [0:0]                    in_tuser,   // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // offset, store_enable, store_data,
                                                    // mirror_vertical, zero pad
  output logic [2:0]                    out_tuser   // target
);

  logic                  in_valid_r;
  logic                  opcode_r;
  logic [15:0]           address_r;
  logic [7:0]            data_r;
  logic                  out_valid_r;
  slbm_pkg::map_result_t res_r;
  slbm_pkg::map_result_t res_nxt;
  slbm_pkg::map_state_t  state;
  logic                  mirror_after;
  logic                  advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      opcode_r  <= in_tuser[0];
      address_r <= in_tdata[15:0];
      data_r    <= in_tdata[23:16];
    end
  end

  slbm_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .step         (advance),
    .opcode       (opcode_r),
    .address      (address_r),
    .data_in      (data_r),
    .state        (state),
    .mirror_after (mirror_after)
  );

  slbm_map u_map (
    .state        (state),
    .mirror_after (mirror_after),
    .opcode       (opcode_r),
    .address      (address_r),
    .data_in      (data_r),
    .result       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.target;
  assign out_tdata  = {4'd0, res_r.mirror_vertical, res_r.store_data,
                       res_r.store_enable, res_r.offset};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r) |-> in_tready)
    else $error("input stalled with result register empty");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request not presented");

  a_store_only_mem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.store_enable) |->
      (res_r.target == slbm_pkg::TGT_CHR || res_r.target == slbm_pkg::TGT_PRG_RAM))
    else $error("store flagged outside CHR or PRG RAM");

endmodule
